// ===== src/scdc_pkg.sv =====
// ----------------------------------------------------------------------------
// scdc_pkg - shared types and constants for the skin color distance classifier
// Field widths, register indexes, reset values and the word types passed
// between the pipeline parts.
// ----------------------------------------------------------------------------
package scdc_pkg;

	localparam int CH_W       = 8;   // color channel
	localparam int THR_W      = 9;   // distance thresholds
	localparam int SQ_W       = 16;  // one squared channel difference
	localparam int SUM_W      = 18;  // sum of three squares
	localparam int ROOT_W     = 19;  // isqrt remainder / root path
	localparam int DIST_W     = 9;   // distance, at most 441
	localparam int LEVEL_W    = 8;
	localparam int CFG_W      = 9;   // widest register
	localparam int IDX_W      = 3;
	localparam int SQRT_STEPS = 10;  // one cell per root bit pair
	localparam int QUO_W      = 8;   // step = 200 / span
	localparam int CNT_W      = 4;   // divider step counter, holds QUO_W
	localparam int REM_W      = THR_W + 1;
	localparam int PROD_W     = QUO_W + DIST_W;

	// input to output delay: two front stages, the root cells, three level stages
	localparam int PIPE_LAT   = 2 + SQRT_STEPS + 3;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd200;
	localparam logic [LEVEL_W-1:0] LEVEL_NONE = 8'd0;

	localparam logic [THR_W-1:0] RST_LOW_THR   = 9'd25;
	localparam logic [THR_W-1:0] RST_HIGH_THR  = 9'd35;
	localparam logic [CH_W-1:0]  RST_REF_BLUE  = 8'd30;
	localparam logic [CH_W-1:0]  RST_REF_GREEN = 8'd40;
	localparam logic [CH_W-1:0]  RST_REF_RED   = 8'd48;

	typedef enum logic [IDX_W-1:0] {
		REG_LOW_THR   = 3'd0,
		REG_HIGH_THR  = 3'd1,
		REG_REF_BLUE  = 3'd2,
		REG_REF_GREEN = 3'd3,
		REG_REF_RED   = 3'd4
	} cfg_reg_t;

	// configuration as seen by the pipeline parts
	typedef struct packed {
		logic [THR_W-1:0] low_thr;
		logic [THR_W-1:0] high_thr;
		logic [CH_W-1:0]  ref_blue;
		logic [CH_W-1:0]  ref_green;
		logic [CH_W-1:0]  ref_red;
	} cfg_t;

	// word handed from one root cell to the next
	typedef struct packed {
		logic              valid;
		logic [ROOT_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sqrt_word_t;

endpackage

// ===== src/scdc_front.sv =====
// ----------------------------------------------------------------------------
// scdc_front - squared color distance
// Stage 1 squares the three channel differences, stage 2 sums them and
// seeds the root chain.
// ----------------------------------------------------------------------------
module scdc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [scdc_pkg::CH_W-1:0] blue,
	input  logic [scdc_pkg::CH_W-1:0] green,
	input  logic [scdc_pkg::CH_W-1:0] red,
	input  scdc_pkg::cfg_t          cfg,
	output scdc_pkg::sqrt_word_t    out_word
);
	import scdc_pkg::*;

	logic [CH_W-1:0] diff_b, diff_g, diff_r;
	logic            valid_s1, valid_s2;
	logic [SQ_W-1:0] sq_b_s1, sq_g_s1, sq_r_s1;
	logic [SUM_W-1:0] sum_s2;

	// absolute channel differences
	always_comb begin
		diff_b = (blue  > cfg.ref_blue)  ? blue  - cfg.ref_blue  : cfg.ref_blue  - blue;
		diff_g = (green > cfg.ref_green) ? green - cfg.ref_green : cfg.ref_green - green;
		diff_r = (red   > cfg.ref_red)   ? red   - cfg.ref_red   : cfg.ref_red   - red;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// squares, then their sum
	always_ff @(posedge clk) begin
		sq_b_s1 <= SQ_W'(diff_b) * SQ_W'(diff_b);
		sq_g_s1 <= SQ_W'(diff_g) * SQ_W'(diff_g);
		sq_r_s1 <= SQ_W'(diff_r) * SQ_W'(diff_r);
		sum_s2  <= SUM_W'(sq_b_s1) + SUM_W'(sq_g_s1) + SUM_W'(sq_r_s1);
	end

	assign out_word.valid = valid_s2;
	assign out_word.rem   = ROOT_W'(sum_s2);
	assign out_word.root  = '0;

endmodule

// ===== src/scdc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// scdc_sqrt_cell - one step of the restoring integer square root
// Tries one root bit pair against the remainder and registers the word
// for the next cell.
// ----------------------------------------------------------------------------
module scdc_sqrt_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [scdc_pkg::ROOT_W-1:0] trial_bit,
	input  scdc_pkg::sqrt_word_t        in_word,
	output scdc_pkg::sqrt_word_t        out_word
);
	import scdc_pkg::*;

	logic [ROOT_W-1:0] trial;
	logic [ROOT_W-1:0] rem_d, root_d;
	logic              valid_q;
	logic [ROOT_W-1:0] rem_q, root_q;

	// compare and restore
	always_comb begin
		trial = in_word.root + trial_bit;
		if (in_word.rem >= trial) begin
			rem_d  = in_word.rem - trial;
			root_d = (in_word.root >> 1) + trial_bit;
		end else begin
			rem_d  = in_word.rem;
			root_d = in_word.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_word.valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_d;
		root_q <= root_d;
	end

	assign out_word.valid = valid_q;
	assign out_word.rem   = rem_q;
	assign out_word.root  = root_q;

endmodule

// ===== src/scdc_step_div.sv =====
// ----------------------------------------------------------------------------
// scdc_step_div - level step from the threshold span
// Bit-serial restoring division of 200 by (high - low). Restarts after
// reset and after every register write.
// ----------------------------------------------------------------------------
module scdc_step_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  scdc_pkg::cfg_t             cfg,
	output logic [scdc_pkg::QUO_W-1:0] step
);
	import scdc_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [THR_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [THR_W-1:0] span;
	logic [2:0]       bit_idx;
	logic [REM_W-1:0] trial;

	// empty band: any nonzero span keeps the divider defined, step unused
	always_comb begin
		span    = (cfg.high_thr > cfg.low_thr) ? cfg.high_thr - cfg.low_thr : THR_W'(1);
		bit_idx = 3'(cnt_q - CNT_W'(1));
		trial   = {rem_q, LEVEL_FULL[bit_idx]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(QUO_W);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cfg_we) begin
			cnt_q <= CNT_W'(QUO_W);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (trial >= REM_W'(span)) begin
				rem_q          <= THR_W'(trial - REM_W'(span));
				quo_q[bit_idx] <= 1'b1;
			end else begin
				rem_q <= THR_W'(trial);
			end
		end
	end

	assign step = quo_q;

endmodule

// ===== src/scdc_level.sv =====
// ----------------------------------------------------------------------------
// scdc_level - distance to skin level
// Three stages: threshold compare and offset, step multiply, final select.
// ----------------------------------------------------------------------------
module scdc_level (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [scdc_pkg::DIST_W-1:0]  distance,
	input  scdc_pkg::cfg_t               cfg,
	input  logic [scdc_pkg::QUO_W-1:0]   step,
	output logic                         done,
	output logic [scdc_pkg::LEVEL_W-1:0] skin_level
);
	import scdc_pkg::*;

	logic              valid_s1, valid_s2, done_q;
	logic              full_s1, zero_s1, full_s2, zero_s2;
	logic [DIST_W-1:0] off_s1;
	logic [QUO_W-1:0]  step_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [LEVEL_W-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		// compare against both thresholds
		full_s1 <= distance <= cfg.low_thr;
		zero_s1 <= distance > cfg.high_thr;
		off_s1  <= distance - cfg.low_thr;
		step_s1 <= step;
		// step times distance past the low threshold
		full_s2 <= full_s1;
		zero_s2 <= zero_s1;
		prod_s2 <= PROD_W'(step_s1) * PROD_W'(off_s1);
		// in band the product never exceeds 200
		priority if (full_s2) begin
			level_q <= LEVEL_FULL;
		end else if (zero_s2) begin
			level_q <= LEVEL_NONE;
		end else begin
			level_q <= LEVEL_FULL - prod_s2[LEVEL_W-1:0];
		end
	end

	assign done       = done_q;
	assign skin_level = level_q;

endmodule

// ===== src/skin_color_distance_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// skin_color_distance_classifier_unit - BGR pixel to skin level
// Pipeline from start to done: 2 square/sum stages, 10 root cells,
// 3 level stages. Throughput: one pixel per cycle; busy stays low.
// Results leave on done for one cycle; the receiver cannot stall.
// Reset clears all valid bits and restores the registers; the step divider
// then runs anew (also after each write), after reset ahead of any pixel.
// ----------------------------------------------------------------------------
module skin_color_distance_classifier_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [scdc_pkg::CH_W-1:0]    blue,
	input  logic [scdc_pkg::CH_W-1:0]    green,
	input  logic [scdc_pkg::CH_W-1:0]    red,
	input  logic                         cfg_we,
	input  logic [scdc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [scdc_pkg::CFG_W-1:0]   cfg_data,
	output logic                         done,
	output logic [scdc_pkg::LEVEL_W-1:0] skin_level
);
	import scdc_pkg::*;

	cfg_t              cfg_q;
	sqrt_word_t        chain [0:SQRT_STEPS];
	logic [QUO_W-1:0]  step;
	logic [DIST_W-1:0] distance;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_thr   <= RST_LOW_THR;
			cfg_q.high_thr  <= RST_HIGH_THR;
			cfg_q.ref_blue  <= RST_REF_BLUE;
			cfg_q.ref_green <= RST_REF_GREEN;
			cfg_q.ref_red   <= RST_REF_RED;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_THR:   cfg_q.low_thr   <= cfg_data;
				REG_HIGH_THR:  cfg_q.high_thr  <= cfg_data;
				REG_REF_BLUE:  cfg_q.ref_blue  <= cfg_data[CH_W-1:0];
				REG_REF_GREEN: cfg_q.ref_green <= cfg_data[CH_W-1:0];
				REG_REF_RED:   cfg_q.ref_red   <= cfg_data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	scdc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.blue     (blue),
		.green    (green),
		.red      (red),
		.cfg      (cfg_q),
		.out_word (chain[0])
	);

	// root cells, most significant bit pair first
	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
		localparam logic [ROOT_W-1:0] TBIT = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - i));
		scdc_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.trial_bit (TBIT),
			.in_word   (chain[i]),
			.out_word  (chain[i+1])
		);
	end

	assign distance = chain[SQRT_STEPS].root[DIST_W-1:0];

	scdc_step_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg    (cfg_q),
		.step   (step)
	);

	scdc_level u_level (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (chain[SQRT_STEPS].valid),
		.distance   (distance),
		.cfg        (cfg_q),
		.step       (step),
		.done       (done),
		.skin_level (skin_level)
	);

endmodule

// ===== src/scdc_checker.sv =====
// ----------------------------------------------------------------------------
// scdc_checker - port level checks for the classifier
// One word out for every word in, a fixed delay later, in range.
// ----------------------------------------------------------------------------
module scdc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [scdc_pkg::CH_W-1:0]    blue,
	input logic [scdc_pkg::CH_W-1:0]    green,
	input logic [scdc_pkg::CH_W-1:0]    red,
	input logic                         cfg_we,
	input logic [scdc_pkg::IDX_W-1:0]   cfg_index,
	input logic [scdc_pkg::CFG_W-1:0]   cfg_data,
	input logic                         done,
	input logic [scdc_pkg::LEVEL_W-1:0] skin_level
);
	import scdc_pkg::*;

	logic [4:0] warm_q;
	logic       accept;

	assign accept = start && !busy;

	// edges since reset release, saturating at the pipeline delay
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != 5'(PIPE_LAT)) begin
			warm_q <= warm_q + 5'd1;
		end
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_word_delay: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == 5'(PIPE_LAT)) |-> (done == $past(accept, PIPE_LAT)))
		else $error("result word not matched to an accepted word");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q != 5'(PIPE_LAT)) |-> !done)
		else $error("result word before any word could pass");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (skin_level <= LEVEL_FULL))
		else $error("skin level out of range");

endmodule

bind skin_color_distance_classifier_unit scdc_checker u_scdc_checker (.*);
